### src/fixed_point_xyz_vertex_rotation_unit_defines.svh
// Assertion macros shared by the vertex rotation unit RTL.
`ifndef FIXED_POINT_XYZ_VERTEX_ROTATION_UNIT_DEFINES_SVH
`define FIXED_POINT_XYZ_VERTEX_ROTATION_UNIT_DEFINES_SVH

`ifndef SYNTH
`define FXVR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fxvr assertion failed");
`define FXVR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fxvr assertion failed");
`else
`define FXVR_ASSERT_IMP(lbl, ante, cons)
`define FXVR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### src/fxvr_pkg.sv
// Package: types, constants and sine/cosine lookup for the vertex rotation unit.
`default_nettype none

package fxvr_pkg;

  localparam int ANGLE_STEPS = 360;
  localparam int QUARTER     = ANGLE_STEPS / 4;
  localparam int FRAC_BITS   = 8;
  localparam int VEC_W       = 16;
  localparam int ANGLE_W     = 9;
  localparam int TRIG_W      = FRAC_BITS + 2;
  localparam int PROD_W      = VEC_W + TRIG_W;
  localparam int CFG_IDX_W   = 2;

  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [ANGLE_W-1:0]       angle_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_X = 2'd0,
    REG_ANGLE_Y = 2'd1,
    REG_ANGLE_Z = 2'd2
  } cfg_reg_t;

  localparam trig_t TRIG_ONE   = trig_t'(1 << FRAC_BITS);
  localparam prod_t TRUNC_BIAS = prod_t'((1 << FRAC_BITS) - 1);
  localparam vec_t  CENTRE_X   = vec_t'(64 << FRAC_BITS);
  localparam vec_t  CENTRE_Y   = vec_t'(32 << FRAC_BITS);

  // trunc(256*sin(k deg)), k = 0..90
  localparam logic [8:0] QSIN [0:90] = '{
    9'd0,   9'd4,   9'd8,   9'd13,  9'd17,  9'd22,  9'd26,  9'd31,  9'd35,  9'd40,
    9'd44,  9'd48,  9'd53,  9'd57,  9'd61,  9'd66,  9'd70,  9'd74,  9'd79,  9'd83,
    9'd87,  9'd91,  9'd95,  9'd100, 9'd104, 9'd108, 9'd112, 9'd116, 9'd120, 9'd124,
    9'd128, 9'd131, 9'd135, 9'd139, 9'd143, 9'd146, 9'd150, 9'd154, 9'd157, 9'd161,
    9'd164, 9'd167, 9'd171, 9'd174, 9'd177, 9'd181, 9'd184, 9'd187, 9'd190, 9'd193,
    9'd196, 9'd198, 9'd201, 9'd204, 9'd207, 9'd209, 9'd212, 9'd214, 9'd217, 9'd219,
    9'd221, 9'd223, 9'd226, 9'd228, 9'd230, 9'd232, 9'd233, 9'd235, 9'd237, 9'd238,
    9'd240, 9'd242, 9'd243, 9'd244, 9'd246, 9'd247, 9'd248, 9'd249, 9'd250, 9'd251,
    9'd252, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255, 9'd255, 9'd255, 9'd255, 9'd255,
    9'd256
  };

  function automatic angle_t angle_wrap(input angle_t ang);
    return (ang >= angle_t'(ANGLE_STEPS)) ? angle_t'(ang - angle_t'(ANGLE_STEPS)) : ang;
  endfunction

  function automatic trig_t sine_fix(input angle_t ang);
    angle_t            a;
    logic [1:0]        q;
    logic [6:0]        r;
    logic [8:0]        mag;
    logic [TRIG_W-1:0] mag_s;
    a = angle_wrap(ang);
    if (a < angle_t'(QUARTER)) begin
      q = 2'd0;
      r = 7'(a);
    end else if (a < angle_t'(2 * QUARTER)) begin
      q = 2'd1;
      r = 7'(a - angle_t'(QUARTER));
    end else if (a < angle_t'(3 * QUARTER)) begin
      q = 2'd2;
      r = 7'(a - angle_t'(2 * QUARTER));
    end else begin
      q = 2'd3;
      r = 7'(a - angle_t'(3 * QUARTER));
    end
    if (!q[0]) begin
      mag = QSIN[r];
    end else begin
      mag = QSIN[7'(7'(QUARTER) - r)];
    end
    // table is in 1/256 units; rescale to FRAC_BITS, truncating
    mag_s = TRIG_W'((32'(mag) << FRAC_BITS) >> 8);
    return q[1] ? -trig_t'(mag_s) : trig_t'(mag_s);
  endfunction

  function automatic trig_t cosine_fix(input angle_t ang);
    logic [ANGLE_W:0] b;
    b = {1'b0, angle_wrap(ang)} + (ANGLE_W+1)'(QUARTER);
    if (b >= (ANGLE_W+1)'(ANGLE_STEPS)) begin
      b = b - (ANGLE_W+1)'(ANGLE_STEPS);
    end
    return sine_fix(angle_t'(b));
  endfunction

endpackage

`default_nettype wire

### src/fxvr_rot_stage.sv
// Two-stage planar rotation: u = a*c - b*s, v = a*s + b*c, 8.8 truncating products.
`default_nettype none
`include "fixed_point_xyz_vertex_rotation_unit_defines.svh"

module fxvr_rot_stage
  import fxvr_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  input  vec_t  in_a,
  input  vec_t  in_b,
  input  vec_t  in_pass,
  input  trig_t in_c,
  input  trig_t in_s,
  output logic  out_valid,
  output vec_t  out_u,
  output vec_t  out_v,
  output vec_t  out_pass
);

  function automatic vec_t fmul_trunc(input prod_t p);
    prod_t t;
    t = p + (p[PROD_W-1] ? TRUNC_BIAS : prod_t'(0));
    return t[FRAC_BITS+VEC_W-1:FRAC_BITS];
  endfunction

  logic  vld1_r, vld2_r;
  prod_t ac_r, bs_r, as_r, bc_r;
  vec_t  pass1_r, pass2_r;
  vec_t  u_r, v_r;
  vec_t  u_nxt, v_nxt;

  // stage 1: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ac_r    <= prod_t'(in_a) * prod_t'(in_c);
    bs_r    <= prod_t'(in_b) * prod_t'(in_s);
    as_r    <= prod_t'(in_a) * prod_t'(in_s);
    bc_r    <= prod_t'(in_b) * prod_t'(in_c);
    pass1_r <= in_pass;
  end

  // stage 2: truncate and combine
  always_comb begin
    u_nxt = fmul_trunc(ac_r) - fmul_trunc(bs_r);
    v_nxt = fmul_trunc(as_r) + fmul_trunc(bc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    pass2_r <= pass1_r;
  end

  assign out_valid = vld2_r;
  assign out_u     = u_r;
  assign out_v     = v_r;
  assign out_pass  = pass2_r;

  `FXVR_ASSERT_IMP(a_rot_latency, vld2_r, $past(in_valid, 2))
  `FXVR_ASSERT_IMP(a_rot_pass_align, vld2_r, pass2_r == $past(in_pass, 2))
  `FXVR_ASSERT_IMP(a_rot_identity,
                   vld2_r && $past((in_c == TRIG_ONE) && (in_s == '0), 2),
                   (u_r == $past(in_a, 2)) && (v_r == $past(in_b, 2)))

endmodule

`default_nettype wire

### src/fixed_point_xyz_vertex_rotation_unit.sv
// Top level: X-then-Y-then-Z fixed-point vertex rotation with screen projection.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------------
//  input    | start / busy           | in_vertex_x, in_vertex_y, in_vertex_z
//  result   | out_valid (strobe)     | out_rotated_x/y/z, out_screen_x, out_screen_y
//  config   | cfg_wr_en              | cfg_index, cfg_wr_data
//
// One request per cycle; busy stays low. Each result passes through the input register,
// two stages for each of the three axis rotations, and the output register.
// The receiver cannot stall, so the pipeline never holds.
// Synchronous reset clears valid bits and sets all angles to 0.
`default_nettype none
`include "fixed_point_xyz_vertex_rotation_unit_defines.svh"

module fixed_point_xyz_vertex_rotation_unit
  import fxvr_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  vec_t                 in_vertex_x,
  input  vec_t                 in_vertex_y,
  input  vec_t                 in_vertex_z,
  output logic                 out_valid,
  output vec_t                 out_rotated_x,
  output vec_t                 out_rotated_y,
  output vec_t                 out_rotated_z,
  output vec_t                 out_screen_x,
  output vec_t                 out_screen_y,
  input  wire                  cfg_wr_en,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [ANGLE_W-1:0]    cfg_wr_data
);

  trig_t sin_x_r, cos_x_r, sin_y_r, cos_y_r, sin_z_r, cos_z_r;

  logic vld0_r;
  vec_t vx_r, vy_r, vz_r;

  logic vld_x, vld_y, vld_z;
  vec_t y1, z1, x1p;
  vec_t z2, x2, y1p;
  vec_t x3, y3, z2p;

  logic vld_out_r;
  vec_t rx_r, ry_r, rz_r, scx_r, scy_r;
  vec_t half_x, half_y, scx_nxt, scy_nxt;

  assign busy = 1'b0;

  // angle registers held as scaled sine/cosine
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sin_x_r <= '0;
      cos_x_r <= TRIG_ONE;
      sin_y_r <= '0;
      cos_y_r <= TRIG_ONE;
      sin_z_r <= '0;
      cos_z_r <= TRIG_ONE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ANGLE_X: begin
          sin_x_r <= sine_fix(cfg_wr_data);
          cos_x_r <= cosine_fix(cfg_wr_data);
        end
        REG_ANGLE_Y: begin
          sin_y_r <= sine_fix(cfg_wr_data);
          cos_y_r <= cosine_fix(cfg_wr_data);
        end
        REG_ANGLE_Z: begin
          sin_z_r <= sine_fix(cfg_wr_data);
          cos_z_r <= cosine_fix(cfg_wr_data);
        end
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    vx_r <= in_vertex_x;
    vy_r <= in_vertex_y;
    vz_r <= in_vertex_z;
  end

  // about X: y1 = y*cx - z*sx, z1 = y*sx + z*cx
  fxvr_rot_stage u_rot_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld0_r),
    .in_a      (vy_r),
    .in_b      (vz_r),
    .in_pass   (vx_r),
    .in_c      (cos_x_r),
    .in_s      (sin_x_r),
    .out_valid (vld_x),
    .out_u     (y1),
    .out_v     (z1),
    .out_pass  (x1p)
  );

  // about Y: z2 = z1*cy - x*sy, x2 = z1*sy + x*cy
  fxvr_rot_stage u_rot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_x),
    .in_a      (z1),
    .in_b      (x1p),
    .in_pass   (y1),
    .in_c      (cos_y_r),
    .in_s      (sin_y_r),
    .out_valid (vld_y),
    .out_u     (z2),
    .out_v     (x2),
    .out_pass  (y1p)
  );

  // about Z: x3 = x2*cz - y1*sz, y3 = x2*sz + y1*cz
  fxvr_rot_stage u_rot_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_y),
    .in_a      (x2),
    .in_b      (y1p),
    .in_pass   (z2),
    .in_c      (cos_z_r),
    .in_s      (sin_z_r),
    .out_valid (vld_z),
    .out_u     (x3),
    .out_v     (y3),
    .out_pass  (z2p)
  );

  // halve toward zero, add screen centre
  always_comb begin
    half_x  = vec_t'(x3 + vec_t'(x3[VEC_W-1])) >>> 1;
    half_y  = vec_t'(y3 + vec_t'(y3[VEC_W-1])) >>> 1;
    scx_nxt = half_x + CENTRE_X;
    scy_nxt = half_y + CENTRE_Y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else begin
      vld_out_r <= vld_z;
    end
  end

  always_ff @(posedge clk) begin
    rx_r  <= x3;
    ry_r  <= y3;
    rz_r  <= z2p;
    scx_r <= scx_nxt;
    scy_r <= scy_nxt;
  end

  assign out_valid     = vld_out_r;
  assign out_rotated_x = rx_r;
  assign out_rotated_y = ry_r;
  assign out_rotated_z = rz_r;
  assign out_screen_x  = scx_r;
  assign out_screen_y  = scy_r;

  `FXVR_ASSERT_IMP(a_top_latency, out_valid, $past(start, 8))
  `FXVR_ASSERT_IMP(a_trig_x_range, 1'b1,
                   (sin_x_r <= TRIG_ONE) && (sin_x_r >= -TRIG_ONE) &&
                   (cos_x_r <= TRIG_ONE) && (cos_x_r >= -TRIG_ONE))
  `FXVR_ASSERT_IMP(a_trig_y_range, 1'b1,
                   (sin_y_r <= TRIG_ONE) && (sin_y_r >= -TRIG_ONE) &&
                   (cos_y_r <= TRIG_ONE) && (cos_y_r >= -TRIG_ONE))
  `FXVR_ASSERT_NXT(a_cfg_ignored,
                   cfg_wr_en && (cfg_index != REG_ANGLE_X) &&
                   (cfg_index != REG_ANGLE_Y) && (cfg_index != REG_ANGLE_Z),
                   $stable(sin_z_r) && $stable(cos_z_r) &&
                   $stable(sin_x_r) && $stable(sin_y_r))

endmodule

`default_nettype wire
